/* design/fbwp_pkg.sv */
// Package for the flash block pool wear picker.
// Holds sizes, tag and request codes, FSM states and the control structs.
// No dependencies.
package fbwp_pkg;

  localparam int unsigned NumBlocks   = 1024;
  localparam int unsigned WearW       = 16;
  localparam int unsigned IdxW        = $clog2(NumBlocks);
  localparam int unsigned BlockW      = 10;
  localparam int unsigned EcW         = 16;
  localparam int unsigned CountW      = 11;
  localparam int unsigned TotW        = $clog2(NumBlocks + 1);
  localparam int unsigned EntryW      = WearW + 2;
  localparam logic [15:0] ThreshReset = 16'd1024;

  typedef enum logic [1:0] {
    TAG_NONE   = 2'd0,
    TAG_USED   = 2'd1,
    TAG_ERASED = 2'd2,
    TAG_FREE   = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    KIND_ADD_USED   = 2'd0,
    KIND_ADD_ERASED = 2'd1,
    KIND_ADD_FREE   = 2'd2,
    KIND_ALLOC      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_req;
    logic clr_wr;
    logic rd_req;
    logic scan_rd;
    logic commit;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic cnt_last;
    logic need_scan;
    logic out_free;
  } sts_t;

endpackage

/* design/fbwp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fbwp_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fbwp_ctrl.sv */
// Sequencer of the wear picker: clear pass, lookup, scan and result steps.
// Depends on fbwp_pkg.
module fbwp_ctrl
  import fbwp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.in_alloc ? ST_SCAN : ST_READ;
      end
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.need_scan ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (sts_i.cnt_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ST_READ:   cmd_o.rd_req  = 1'b1;
      ST_CHECK:  cmd_o.commit  = 1'b1;
      ST_SCAN:   cmd_o.scan_rd = 1'b1;
      ST_DRAIN:  cmd_o = '0;
      ST_FINISH: cmd_o.finish  = 1'b1;
      ST_DONE:   cmd_o.out_load = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

/* design/fbwp_dp.sv */
// Datapath of the wear picker: block table RAM, scan trackers, pool totals,
// wear delta, threshold register and result register.
// Depends on fbwp_pkg and fbwp_ram.
module fbwp_dp
  import fbwp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        kind_i,
  input  logic [BlockW-1:0] block_i,
  input  logic [EcW-1:0]    erase_count_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       wear_delta_threshold_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              granted_o,
  output logic [BlockW-1:0] out_block_o,
  output logic              needs_erase_o,
  output logic              no_block_o,
  output logic [15:0]       wear_delta_o,
  output logic              wear_level_due_o,
  output logic [CountW-1:0] erased_count_o,
  output logic [CountW-1:0] free_count_o,
  output logic [CountW-1:0] used_count_o
);

  kind_e             req_kind_q;
  logic [BlockW-1:0] req_blk_q;
  logic [WearW-1:0]  req_ec_q;
  logic [IdxW-1:0]   cnt_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              a_found_q, b_found_q;
  logic [IdxW-1:0]   a_blk_q, b_blk_q;
  logic [WearW-1:0]  a_wear_q, b_wear_q;
  logic [TotW-1:0]   used_q, used_d, erased_q, erased_d, free_q, free_d;
  logic [WearW-1:0]  delta_q, delta_d;
  logic [15:0]       thresh_q;
  logic              res_granted_q, res_erase_q, res_none_q;
  logic [IdxW-1:0]   res_blk_q;
  logic              out_valid_q;
  logic              granted_q, needs_erase_q, no_block_q, due_q;
  logic [BlockW-1:0] out_block_q;
  logic [15:0]       wear_delta_q;
  logic [CountW-1:0] erased_cnt_q, free_cnt_q, used_cnt_q;

  logic              we, re;
  logic [IdxW-1:0]   waddr, raddr, req_idx;
  logic [EntryW-1:0] wdata, rd_data;
  tag_e              rd_tag, new_tag, tag_a;
  logic [WearW-1:0]  rd_wear;
  logic              is_alloc, in_range, remove, join_ok;
  logic [TotW-1:0]   used_after;

  fbwp_ram #(
    .Width(EntryW),
    .Depth(NumBlocks)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  assign req_idx  = IdxW'(req_blk_q);
  assign is_alloc = (req_kind_q == KIND_ALLOC);
  assign in_range = (32'(req_blk_q) < NumBlocks);
  assign rd_tag   = tag_e'(rd_data[EntryW-1 -: 2]);
  assign rd_wear  = rd_data[WearW-1:0];
  assign tag_a    = is_alloc ? TAG_ERASED : TAG_USED;

  always_comb begin
    case (req_kind_q)
      KIND_ADD_USED:   new_tag = TAG_USED;
      KIND_ADD_ERASED: new_tag = TAG_ERASED;
      KIND_ADD_FREE:   new_tag = TAG_FREE;
      default:         new_tag = TAG_NONE;
    endcase
  end

  assign remove = in_range && (req_kind_q != KIND_ADD_USED) && (rd_tag == TAG_USED) &&
                  (rd_wear == req_ec_q);
  assign join_ok = in_range && ((rd_tag == TAG_NONE) || remove);
  assign used_after = (remove && used_q != '0) ? used_q - TotW'(1) : used_q;

  assign sts_o.in_alloc  = (kind_e'(kind_i) == KIND_ALLOC);
  assign sts_o.cnt_last  = (cnt_q == IdxW'(NumBlocks - 1));
  assign sts_o.need_scan = join_ok && (req_kind_q == KIND_ADD_FREE) && (used_after != '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = '0;
    if (cmd_i.clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.commit) begin
      we    = join_ok;
      waddr = req_idx;
      wdata = {new_tag, req_ec_q};
    end else if (cmd_i.finish && is_alloc) begin
      we    = a_found_q || b_found_q;
      waddr = a_found_q ? a_blk_q : b_blk_q;
      wdata = {TAG_NONE, WearW'(0)};
    end
  end

  assign re    = cmd_i.rd_req || cmd_i.scan_rd;
  assign raddr = cmd_i.scan_rd ? cnt_q : req_idx;

  always_comb begin
    used_d   = used_q;
    erased_d = erased_q;
    free_d   = free_q;
    delta_d  = delta_q;
    if (cmd_i.commit) begin
      used_d = used_after;
      if (join_ok) begin
        case (new_tag)
          TAG_USED:   used_d   = used_after + TotW'(1);
          TAG_ERASED: erased_d = erased_q + TotW'(1);
          TAG_FREE:   free_d   = free_q + TotW'(1);
          default:    used_d   = used_after;
        endcase
      end
    end else if (cmd_i.finish) begin
      if (is_alloc) begin
        if (a_found_q) begin
          if (erased_q != '0) erased_d = erased_q - TotW'(1);
        end else if (b_found_q) begin
          if (free_q != '0) free_d = free_q - TotW'(1);
        end
      end else if (a_found_q && req_ec_q > a_wear_q && a_wear_q != '0 && req_ec_q != '0) begin
        delta_d = req_ec_q - a_wear_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      a_found_q   <= 1'b0;
      b_found_q   <= 1'b0;
      used_q      <= '0;
      erased_q    <= '0;
      free_q      <= '0;
      delta_q     <= '0;
      thresh_q    <= ThreshReset;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      used_q   <= used_d;
      erased_q <= erased_d;
      free_q   <= free_d;
      delta_q  <= delta_d;
      if (cfg_valid_i) begin
        thresh_q <= wear_delta_threshold_i;
      end
      if (cmd_i.load_req) begin
        cnt_q <= '0;
      end else if (cmd_i.clr_wr || cmd_i.scan_rd) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (cmd_i.load_req) begin
        a_found_q <= 1'b0;
        b_found_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (rd_tag == tag_a && (!a_found_q || rd_wear < a_wear_q)) begin
          a_found_q <= 1'b1;
        end
        if (rd_tag == TAG_FREE && (!b_found_q || rd_wear < b_wear_q)) begin
          b_found_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.load_req) begin
      req_kind_q    <= kind_e'(kind_i);
      req_blk_q     <= block_i;
      req_ec_q      <= erase_count_i[WearW-1:0];
      res_granted_q <= 1'b0;
      res_erase_q   <= 1'b0;
      res_none_q    <= 1'b0;
      res_blk_q     <= '0;
    end
    if (rd_vld_q) begin
      if (rd_tag == tag_a && (!a_found_q || rd_wear < a_wear_q)) begin
        a_blk_q  <= rd_idx_q;
        a_wear_q <= rd_wear;
      end
      if (rd_tag == TAG_FREE && (!b_found_q || rd_wear < b_wear_q)) begin
        b_blk_q  <= rd_idx_q;
        b_wear_q <= rd_wear;
      end
    end
    if (cmd_i.finish && is_alloc) begin
      res_granted_q <= a_found_q || b_found_q;
      res_erase_q   <= !a_found_q && b_found_q;
      res_none_q    <= !a_found_q && !b_found_q;
      res_blk_q     <= a_found_q ? a_blk_q : (b_found_q ? b_blk_q : '0);
    end
    if (cmd_i.out_load) begin
      granted_q     <= res_granted_q;
      out_block_q   <= BlockW'(res_blk_q);
      needs_erase_q <= res_erase_q;
      no_block_q    <= res_none_q;
      wear_delta_q  <= 16'(delta_q);
      due_q         <= (16'(delta_q) >= thresh_q);
      erased_cnt_q  <= CountW'(erased_q);
      free_cnt_q    <= CountW'(free_q);
      used_cnt_q    <= CountW'(used_q);
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign granted_o        = granted_q;
  assign out_block_o      = out_block_q;
  assign needs_erase_o    = needs_erase_q;
  assign no_block_o       = no_block_q;
  assign wear_delta_o     = wear_delta_q;
  assign wear_level_due_o = due_q;
  assign erased_count_o   = erased_cnt_q;
  assign free_count_o     = free_cnt_q;
  assign used_count_o     = used_cnt_q;

endmodule

/* design/flash_block_pool_wear_picker_unit.sv */
// Top level of the flash block pool wear picker: sequencer plus datapath.
// Depends on fbwp_pkg, fbwp_ctrl, fbwp_dp (and fbwp_ram below it).
//
//   channel | handshake                   | payload
//   --------+-----------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o     | kind_i, block_i, erase_count_i
//   out     | out_valid_o / out_stall_i   | granted_o .. used_count_o
//   cfg     | cfg_valid_i / cfg_ready_o   | wear_delta_threshold_i
//
// Add to used or erased pool: one table read, then the result.
// Allocate, or add to free pool with a nonempty used pool: a full scan of the
// block table RAM, one entry per cycle, then the result.
// After reset a clearing pass over all NumBlocks (1024) entries runs with in_stall_o high.
// A held result stalls the unit at its final step until out_stall_i drops.
module flash_block_pool_wear_picker_unit
  import fbwp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [BlockW-1:0] block_i,
  input  logic [EcW-1:0]    erase_count_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       wear_delta_threshold_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              granted_o,
  output logic [BlockW-1:0] out_block_o,
  output logic              needs_erase_o,
  output logic              no_block_o,
  output logic [15:0]       wear_delta_o,
  output logic              wear_level_due_o,
  output logic [CountW-1:0] erased_count_o,
  output logic [CountW-1:0] free_count_o,
  output logic [CountW-1:0] used_count_o
);

  cmd_t cmd;
  sts_t sts;

  fbwp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  fbwp_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .kind_i                (kind_i),
    .block_i               (block_i),
    .erase_count_i         (erase_count_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .wear_delta_threshold_i(wear_delta_threshold_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .granted_o             (granted_o),
    .out_block_o           (out_block_o),
    .needs_erase_o         (needs_erase_o),
    .no_block_o            (no_block_o),
    .wear_delta_o          (wear_delta_o),
    .wear_level_due_o      (wear_level_due_o),
    .erased_count_o        (erased_count_o),
    .free_count_o          (free_count_o),
    .used_count_o          (used_count_o)
  );

endmodule

/* design/fbwp_checker.sv */
// Port-level checker for the wear picker, bound to the top level.
// Depends on fbwp_pkg and flash_block_pool_wear_picker_unit.
module fbwp_checker
  import fbwp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              granted_o,
  input logic [BlockW-1:0] out_block_o,
  input logic              needs_erase_o,
  input logic              no_block_o,
  input logic [CountW-1:0] erased_count_o,
  input logic [CountW-1:0] free_count_o,
  input logic [CountW-1:0] used_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_block_o) &&
    $stable(granted_o))
    else $error("stalled result changed");

  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_block_o |-> !granted_o && erased_count_o == '0 &&
    free_count_o == '0)
    else $error("no block reported with a nonempty pool");

  a_erase_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && needs_erase_o |-> granted_o && erased_count_o == '0)
    else $error("dirty block handed out while erased blocks remain");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(erased_count_o) + 32'(free_count_o) + 32'(used_count_o) <= NumBlocks)
    else $error("pool totals exceed block count");

endmodule

bind flash_block_pool_wear_picker_unit fbwp_checker u_fbwp_checker (.*);

/* test/fbwp_resp_checker.sv */
// Response checker for flash_block_pool_wear_picker_unit: watches the request, response
// and threshold channels, predicts each response and compares it field by field.
// Depends on fbwp_pkg.
`timescale 1ns / 100ps

module fbwp_resp_checker
  import fbwp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        kind_i,
  input  logic [BlockW-1:0] block_i,
  input  logic [EcW-1:0]    erase_count_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [15:0]       wear_delta_threshold_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              granted_i,
  input  logic [BlockW-1:0] out_block_i,
  input  logic              needs_erase_i,
  input  logic              no_block_i,
  input  logic [15:0]       wear_delta_i,
  input  logic              wear_level_due_i,
  input  logic [CountW-1:0] erased_count_i,
  input  logic [CountW-1:0] free_count_i,
  input  logic [CountW-1:0] used_count_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  typedef struct packed {
    logic              granted;
    logic [BlockW-1:0] out_block;
    logic              needs_erase;
    logic              no_block;
    logic [15:0]       wear_delta;
    logic              wear_level_due;
    logic [CountW-1:0] erased_count;
    logic [CountW-1:0] free_count;
    logic [CountW-1:0] used_count;
  } pool_resp_t;

  tag_e        pool_tag   [NumBlocks];
  logic [15:0] block_wear [NumBlocks];
  int          pool_size  [4];
  logic [15:0] wear_delta;
  logic [15:0] threshold;
  pool_resp_t  awaited_resp[$];

  function automatic logic find_coldest(tag_e t, output logic [BlockW-1:0] blk);
    logic        found;
    logic [15:0] bw;
    int          i;
    found = 1'b0;
    blk   = '0;
    bw    = '0;
    for (i = 0; i < NumBlocks; i++) begin
      if (pool_tag[i] == t && (!found || block_wear[i] < bw)) begin
        found = 1'b1;
        blk   = i[BlockW-1:0];
        bw    = block_wear[i];
      end
    end
    return found;
  endfunction

  function automatic void drop_block(logic [BlockW-1:0] blk);
    if (pool_tag[blk] != TAG_NONE) begin
      if (pool_size[pool_tag[blk]] > 0) pool_size[pool_tag[blk]]--;
      pool_tag[blk] = TAG_NONE;
    end
  endfunction

  function automatic pool_resp_t apply_request(kind_e k, logic [BlockW-1:0] blk,
                                               logic [15:0] ec);
    pool_resp_t        r;
    tag_e              t;
    logic [BlockW-1:0] pick;
    r = '0;
    if (k == KIND_ALLOC) begin
      if (find_coldest(TAG_ERASED, pick)) begin
        drop_block(pick);
        r.granted   = 1'b1;
        r.out_block = pick;
      end else if (find_coldest(TAG_FREE, pick)) begin
        drop_block(pick);
        r.granted     = 1'b1;
        r.out_block   = pick;
        r.needs_erase = 1'b1;
      end else begin
        r.no_block = 1'b1;
      end
    end else begin
      if (k != KIND_ADD_USED && pool_tag[blk] == TAG_USED && block_wear[blk] == ec)
        drop_block(blk);
      if (pool_tag[blk] == TAG_NONE) begin
        case (k)
          KIND_ADD_USED:   t = TAG_USED;
          KIND_ADD_ERASED: t = TAG_ERASED;
          default:         t = TAG_FREE;
        endcase
        pool_tag[blk]   = t;
        block_wear[blk] = ec;
        pool_size[t]++;
        if (t == TAG_FREE && find_coldest(TAG_USED, pick)) begin
          if (ec > block_wear[pick] && block_wear[pick] != 0 && ec != 0)
            wear_delta = ec - block_wear[pick];
        end
      end
    end
    r.wear_delta     = wear_delta;
    r.wear_level_due = (wear_delta >= threshold);
    r.erased_count   = pool_size[TAG_ERASED][CountW-1:0];
    r.free_count     = pool_size[TAG_FREE][CountW-1:0];
    r.used_count     = pool_size[TAG_USED][CountW-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_resp_t e;
    int         i;
    if (!rst_ni) begin
      for (i = 0; i < NumBlocks; i++) begin
        pool_tag[i]   = TAG_NONE;
        block_wear[i] = '0;
      end
      for (i = 0; i < 4; i++) pool_size[i] = 0;
      wear_delta   = '0;
      threshold    = ThreshReset;
      awaited_resp.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold = wear_delta_threshold_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_resp.size() == 0) begin
          $error("response transfer with no request outstanding");
          fail_count_o++;
        end else begin
          e = awaited_resp.pop_front();
          checked_o++;
          check_field("granted", 32'(e.granted), 32'(granted_i));
          check_field("out_block", 32'(e.out_block), 32'(out_block_i));
          check_field("needs_erase", 32'(e.needs_erase), 32'(needs_erase_i));
          check_field("no_block", 32'(e.no_block), 32'(no_block_i));
          check_field("wear_delta", 32'(e.wear_delta), 32'(wear_delta_i));
          check_field("wear_level_due", 32'(e.wear_level_due), 32'(wear_level_due_i));
          check_field("erased_count", 32'(e.erased_count), 32'(erased_count_i));
          check_field("free_count", 32'(e.free_count), 32'(free_count_i));
          check_field("used_count", 32'(e.used_count), 32'(used_count_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_resp.push_back(apply_request(kind_e'(kind_i), block_i, erase_count_i));
      pending_o = awaited_resp.size();
    end
  end

endmodule

/* test/tb_flash_block_pool_wear_picker_unit.sv */
// Testbench top for flash_block_pool_wear_picker_unit: clock, reset, threshold writes,
// directed and random pool requests under several idle mixes; verdict from fbwp_resp_checker.
// Depends on fbwp_pkg, flash_block_pool_wear_picker_unit and fbwp_resp_checker.
`timescale 1ns / 100ps

module tb_flash_block_pool_wear_picker_unit;
  import fbwp_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int HoldCycles = 3000;
  localparam int PhaseItems = 132;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        kind_i;
  logic [BlockW-1:0] block_i;
  logic [EcW-1:0]    erase_count_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [15:0]       wear_delta_threshold_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              granted_o;
  logic [BlockW-1:0] out_block_o;
  logic              needs_erase_o;
  logic              no_block_o;
  logic [15:0]       wear_delta_o;
  logic              wear_level_due_o;
  logic [CountW-1:0] erased_count_o;
  logic [CountW-1:0] free_count_o;
  logic [CountW-1:0] used_count_o;

  int          fail_count;
  int          pending;
  int          checked;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_reqs;
  int          hold_left;
  int          n_requests;
  int          n_allocs;
  int          n_settings;
  logic [15:0] last_wear [NumBlocks];

  flash_block_pool_wear_picker_unit dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .kind_i                 (kind_i),
    .block_i                (block_i),
    .erase_count_i          (erase_count_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .wear_delta_threshold_i (wear_delta_threshold_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .granted_o              (granted_o),
    .out_block_o            (out_block_o),
    .needs_erase_o          (needs_erase_o),
    .no_block_o             (no_block_o),
    .wear_delta_o           (wear_delta_o),
    .wear_level_due_o       (wear_level_due_o),
    .erased_count_o         (erased_count_o),
    .free_count_o           (free_count_o),
    .used_count_o           (used_count_o)
  );

  fbwp_resp_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .kind_i                 (kind_i),
    .block_i                (block_i),
    .erase_count_i          (erase_count_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .wear_delta_threshold_i (wear_delta_threshold_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .granted_i              (granted_o),
    .out_block_i            (out_block_o),
    .needs_erase_i          (needs_erase_o),
    .no_block_i             (no_block_o),
    .wear_delta_i           (wear_delta_o),
    .wear_level_due_i       (wear_level_due_o),
    .erased_count_i         (erased_count_o),
    .free_count_i           (free_count_o),
    .used_count_i           (used_count_o),
    .fail_count_o           (fail_count),
    .pending_o              (pending),
    .checked_o              (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int hold_seen;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic push_request(kind_e k, logic [BlockW-1:0] b, logic [EcW-1:0] e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    block_i       <= b;
    erase_count_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    n_requests++;
    if (k == KIND_ALLOC) n_allocs++;
    @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    cfg_valid_i            <= 1'b1;
    wear_delta_threshold_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    kind_e             k;
    logic [BlockW-1:0] b;
    logic [EcW-1:0]    e;
    int                r;
    int                i;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 30) ? KIND_ADD_USED : (r < 48) ? KIND_ADD_ERASED :
          (r < 72) ? KIND_ADD_FREE : KIND_ALLOC;
      b = BlockW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, NumBlocks - 1)
                                              : $urandom_range(0, 47));
      if (k == KIND_ADD_USED || $urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 7))
          0:       e = '0;
          1:       e = '1;
          2, 3:    e = EcW'($urandom);
          default: e = EcW'($urandom_range(1, 3000));
        endcase
      end else begin
        e = last_wear[b];
      end
      last_wear[b] = e;
      push_request(k, b, e);
    end
  endtask

  initial begin
    logic [15:0] setting [4];
    int          p;
    rst_ni                 = 1'b0;
    in_valid_i             = 1'b0;
    kind_i                 = KIND_ADD_USED;
    block_i                = '0;
    erase_count_i          = '0;
    cfg_valid_i            = 1'b0;
    wear_delta_threshold_i = '0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    hold_reqs              = 0;
    n_requests             = 0;
    n_allocs               = 0;
    n_settings             = 0;
    for (p = 0; p < NumBlocks; p++) last_wear[p] = '0;
    setting[0] = 16'd0;
    setting[1] = 16'hFFFF;
    setting[2] = 16'($urandom);
    setting[3] = 16'($urandom_range(1, 3000));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_threshold(ThreshReset);

    push_request(KIND_ALLOC,      10'd0,    16'd0);
    push_request(KIND_ADD_FREE,   10'd3,    16'd500);
    push_request(KIND_ADD_USED,   10'd0,    16'd0);
    push_request(KIND_ADD_USED,   10'd1023, 16'hFFFF);
    push_request(KIND_ADD_USED,   10'd5,    16'd100);
    push_request(KIND_ADD_FREE,   10'd9,    16'd400);
    push_request(KIND_ADD_FREE,   10'd0,    16'd0);
    push_request(KIND_ADD_FREE,   10'd11,   16'd1200);
    push_request(KIND_ADD_FREE,   10'd12,   16'd50);
    push_request(KIND_ADD_ERASED, 10'd5,    16'd99);
    push_request(KIND_ADD_ERASED, 10'd5,    16'd100);
    push_request(KIND_ADD_USED,   10'd5,    16'd7);
    push_request(KIND_ADD_ERASED, 10'd20,   16'd100);
    push_request(KIND_ADD_ERASED, 10'd21,   16'd100);
    push_request(KIND_ADD_ERASED, 10'd1023, 16'hFFFF);
    push_request(KIND_ALLOC,      10'h3FF,  16'hFFFF);
    push_request(KIND_ALLOC,      10'd0,    16'd0);
    push_request(KIND_ALLOC,      10'd0,    16'd0);
    push_request(KIND_ALLOC,      10'd0,    16'd0);
    push_request(KIND_ALLOC,      10'd0,    16'd0);
    push_request(KIND_ADD_FREE,   10'd13,   16'hFFFF);
    push_request(KIND_ADD_USED,   10'd14,   16'd1);
    push_request(KIND_ADD_FREE,   10'd15,   16'hFFFF);
    drain_responses();

    for (p = 0; p < 4; p++) begin
      write_threshold(setting[p]);
      send_idle_pct  = (p == 1) ? 49 : (p == 3) ? 21 : 0;
      recv_stall_pct = (p == 2) ? 49 : (p == 3) ? 21 : 0;
      if (p == 0) hold_reqs++;
      send_random(PhaseItems);
      drain_responses();
    end

    repeat (1100) @(negedge clk_i);
    $display("Covered %0d pool requests (%0d allocations) under %0d threshold settings,",
             n_requests, n_allocs, n_settings);
    $display("four idle mixes and one long response hold; %0d responses compared.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
